>>> hdl/fofrm_pkg.sv
`default_nettype none

package fofrm_pkg;

  localparam int MAX_PARTICLES = 4096;
  localparam int IDX_W         = $clog2(MAX_PARTICLES);
  localparam int POS_BITS      = 24;
  localparam int MAG_W         = POS_BITS + 1;
  localparam int SQ_W          = 2 * MAG_W;
  localparam int DIST_W        = SQ_W + 2;
  localparam int LINK_W        = 50;
  localparam int CMP_W         = (DIST_W > LINK_W) ? DIST_W : LINK_W;
  localparam int SIZE_W        = 13;
  localparam int CFG_W         = 64;
  localparam int PADDR_W       = 4;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_LINK  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [2:0] ST_FAR    = 3'd0;
  localparam logic [2:0] ST_SAME   = 3'd1;
  localparam logic [2:0] ST_MERGED = 3'd2;
  localparam logic [2:0] ST_LOADED = 3'd3;
  localparam logic [2:0] ST_QUERY  = 3'd4;

  localparam logic REG_LINK_DIST_SQ = 1'b0;

  typedef struct packed {
    logic [1:0]         mode;
    logic [11:0]        first_index;
    logic [11:0]        second_index;
    logic signed [23:0] pos_x_in;
    logic signed [23:0] pos_y_in;
    logic signed [23:0] pos_z_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] successor;
    logic [12:0] group_size;
  } out_item_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0] x;
    logic signed [POS_BITS-1:0] y;
    logic signed [POS_BITS-1:0] z;
  } pos_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POS_B,
    S_DIST_GO,
    S_DIST,
    S_WALK,
    S_SWAP_RD,
    S_SWAP_W1,
    S_SWAP_W2,
    S_QUERY,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

>>> hdl/fofrm_ram.sv
`default_nettype none

module fofrm_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/fofrm_dist.sv
`default_nettype none

module fofrm_dist (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire fofrm_pkg::pos_t       pos_a_i,
  input  wire fofrm_pkg::pos_t       pos_b_i,
  output logic                       done_o,
  output logic [fofrm_pkg::DIST_W-1:0] dist_o
);

  function automatic logic [fofrm_pkg::MAG_W-1:0] abs_diff(
    input logic signed [fofrm_pkg::POS_BITS-1:0] a,
    input logic signed [fofrm_pkg::POS_BITS-1:0] b
  );
    logic signed [fofrm_pkg::MAG_W-1:0] d;
    d = fofrm_pkg::MAG_W'(a) - fofrm_pkg::MAG_W'(b);
    return d[fofrm_pkg::MAG_W-1] ? fofrm_pkg::MAG_W'(-d) : fofrm_pkg::MAG_W'(d);
  endfunction

  logic [fofrm_pkg::MAG_W-1:0]  mag_q [3];
  logic [fofrm_pkg::SQ_W-1:0]   sq_q;
  logic [fofrm_pkg::DIST_W-1:0] acc_q;
  logic [1:0]                   phase_q;
  logic                         busy_q;
  logic [fofrm_pkg::SQ_W-1:0]   prod;

  // one squared axis a cycle through a single multiplier
  assign prod = fofrm_pkg::SQ_W'(mag_q[phase_q]) * fofrm_pkg::SQ_W'(mag_q[phase_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 2'd0;
    end else if (start_i) begin
      busy_q  <= 1'b1;
      phase_q <= 2'd0;
    end else if (busy_q) begin
      if (phase_q == 2'd3) begin
        busy_q <= 1'b0;
      end else begin
        phase_q <= phase_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q[0] <= abs_diff(pos_a_i.x, pos_b_i.x);
      mag_q[1] <= abs_diff(pos_a_i.y, pos_b_i.y);
      mag_q[2] <= abs_diff(pos_a_i.z, pos_b_i.z);
      acc_q    <= '0;
    end else if (busy_q && phase_q != 2'd3) begin
      sq_q <= prod;
      if (phase_q != 2'd0) begin
        acc_q <= acc_q + fofrm_pkg::DIST_W'(sq_q);
      end
    end
  end

  assign done_o = busy_q && (phase_q == 2'd3);
  assign dist_o = acc_q + fofrm_pkg::DIST_W'(sq_q);

endmodule

`default_nettype wire

>>> hdl/friends_of_friends_ring_merge_unit.sv
`default_nettype none

// Friends-of-friends group linker. Positions and the ring successor table each live in one
// synchronous RAM; every group of linked particles is a closed ring of successors. One item is
// worked on at a time. A load writes both RAMs when it is taken and then registers its result. A
// link reads the two positions and forms the three-axis squared distance (one multiplier, one
// axis a cycle); unless the pair is too far apart or the same particle, it then walks the ring in
// the successor RAM and, when the rings are spliced, passes S_SWAP_RD, S_SWAP_W1 and S_SWAP_W2,
// then registers the result. A query walks the ring from its particle and registers the result.
// The ring walk, one successor RAM read a cycle, sets the rate for large groups. link_dist_sq is
// a 50-bit register at byte address 0 and should only be written while the block is idle.
module friends_of_friends_ring_merge_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire fofrm_pkg::in_item_t           in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output fofrm_pkg::out_item_t               out_data_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fofrm_pkg::PADDR_W-1:0] paddr,
  input  wire logic [fofrm_pkg::CFG_W-1:0]   pwdata,
  output logic [fofrm_pkg::CFG_W-1:0]        prdata,
  output logic                               pready
);

  localparam int POS_W = $bits(fofrm_pkg::pos_t);

  fofrm_pkg::state_e              state_q, state_d;
  logic [fofrm_pkg::IDX_W-1:0]    a_q, b_q;
  logic [fofrm_pkg::IDX_W-1:0]    cnt_q, cnt_d;
  logic [fofrm_pkg::IDX_W-1:0]    ta_q, ta_d;
  logic [fofrm_pkg::IDX_W-1:0]    succ_q, succ_d;
  fofrm_pkg::pos_t                pa_q, pa_d;
  fofrm_pkg::out_item_t           res_q, res_d;
  fofrm_pkg::out_item_t           out_q;
  logic                           out_valid_q, out_valid_d;
  logic                           out_load;
  logic [fofrm_pkg::LINK_W-1:0]   link_q;

  logic                           pos_we;
  logic [fofrm_pkg::IDX_W-1:0]    pos_raddr;
  fofrm_pkg::pos_t                pos_wdata;
  logic [POS_W-1:0]               pos_rdata_raw;
  fofrm_pkg::pos_t                pos_rdata;

  logic                           ring_we;
  logic [fofrm_pkg::IDX_W-1:0]    ring_waddr, ring_wdata, ring_raddr, ring_rdata;

  logic                           dist_start, dist_done;
  logic [fofrm_pkg::DIST_W-1:0]   dist_sum;
  logic                           too_far;
  logic                           accept;
  logic                           last_step;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0;
    end else if (psel && penable && pwrite && (paddr[3] == fofrm_pkg::REG_LINK_DIST_SQ)) begin
      link_q <= pwdata[fofrm_pkg::LINK_W-1:0];
    end
  end

  assign prdata = (paddr[3] == fofrm_pkg::REG_LINK_DIST_SQ) ? fofrm_pkg::CFG_W'(link_q) : '0;

  // memories
  assign pos_wdata.x = in_data_i.pos_x_in[fofrm_pkg::POS_BITS-1:0];
  assign pos_wdata.y = in_data_i.pos_y_in[fofrm_pkg::POS_BITS-1:0];
  assign pos_wdata.z = in_data_i.pos_z_in[fofrm_pkg::POS_BITS-1:0];
  assign pos_rdata   = fofrm_pkg::pos_t'(pos_rdata_raw);

  fofrm_ram #(
    .WIDTH (POS_W),
    .DEPTH (fofrm_pkg::MAX_PARTICLES)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (in_data_i.first_index),
    .wdata_i (pos_wdata),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata_raw)
  );

  fofrm_ram #(
    .WIDTH (fofrm_pkg::IDX_W),
    .DEPTH (fofrm_pkg::MAX_PARTICLES)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  fofrm_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dist_start),
    .pos_a_i (pa_q),
    .pos_b_i (pos_rdata),
    .done_o  (dist_done),
    .dist_o  (dist_sum)
  );

  assign too_far   = fofrm_pkg::CMP_W'(dist_sum) > fofrm_pkg::CMP_W'(link_q);
  assign accept    = in_valid_i && !in_stall_o;
  assign last_step = (cnt_q == fofrm_pkg::IDX_W'(fofrm_pkg::MAX_PARTICLES - 1));
  assign out_load  = (state_q == fofrm_pkg::S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    pos_we     = 1'b0;
    pos_raddr  = b_q;
    ring_we    = 1'b0;
    ring_waddr = a_q;
    ring_wdata = ring_rdata;
    ring_raddr = a_q;
    dist_start = 1'b0;
    cnt_d      = cnt_q;
    ta_d       = ta_q;
    succ_d     = succ_q;
    pa_d       = pa_q;
    res_d      = res_q;
    case (state_q)
      fofrm_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        pos_raddr  = in_data_i.first_index;
        ring_raddr = in_data_i.first_index;
        cnt_d      = '0;
        if (in_valid_i) begin
          case (in_data_i.mode)
            fofrm_pkg::MODE_LOAD: begin
              pos_we     = 1'b1;
              ring_we    = 1'b1;
              ring_waddr = in_data_i.first_index;
              ring_wdata = in_data_i.first_index;
              res_d      = '{status: fofrm_pkg::ST_LOADED, successor: '0, group_size: '0};
              state_d    = fofrm_pkg::S_DONE;
            end
            fofrm_pkg::MODE_LINK:  state_d = fofrm_pkg::S_POS_B;
            fofrm_pkg::MODE_QUERY: state_d = fofrm_pkg::S_QUERY;
            default:               state_d = fofrm_pkg::S_IDLE;
          endcase
        end
      end
      fofrm_pkg::S_POS_B: begin
        pa_d    = pos_rdata;
        state_d = fofrm_pkg::S_DIST_GO;
      end
      fofrm_pkg::S_DIST_GO: begin
        dist_start = 1'b1;
        state_d    = fofrm_pkg::S_DIST;
      end
      fofrm_pkg::S_DIST: begin
        cnt_d = '0;
        if (dist_done) begin
          if (too_far) begin
            res_d   = '{status: fofrm_pkg::ST_FAR, successor: '0, group_size: '0};
            state_d = fofrm_pkg::S_DONE;
          end else if (a_q == b_q) begin
            res_d   = '{status: fofrm_pkg::ST_SAME, successor: '0, group_size: '0};
            state_d = fofrm_pkg::S_DONE;
          end else begin
            state_d = fofrm_pkg::S_WALK;
          end
        end
      end
      fofrm_pkg::S_WALK: begin
        ring_raddr = ring_rdata;
        if (cnt_q == '0) begin
          ta_d = ring_rdata;
        end
        if (ring_rdata == a_q) begin
          state_d = fofrm_pkg::S_SWAP_RD;
        end else if (ring_rdata == b_q) begin
          res_d   = '{status: fofrm_pkg::ST_SAME, successor: '0, group_size: '0};
          state_d = fofrm_pkg::S_DONE;
        end else if (last_step) begin
          state_d = fofrm_pkg::S_SWAP_RD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      fofrm_pkg::S_SWAP_RD: begin
        ring_raddr = b_q;
        state_d    = fofrm_pkg::S_SWAP_W1;
      end
      fofrm_pkg::S_SWAP_W1: begin
        ring_we    = 1'b1;
        ring_waddr = a_q;
        ring_wdata = ring_rdata;
        state_d    = fofrm_pkg::S_SWAP_W2;
      end
      fofrm_pkg::S_SWAP_W2: begin
        ring_we    = 1'b1;
        ring_waddr = b_q;
        ring_wdata = ta_q;
        res_d      = '{status: fofrm_pkg::ST_MERGED, successor: '0, group_size: '0};
        state_d    = fofrm_pkg::S_DONE;
      end
      fofrm_pkg::S_QUERY: begin
        ring_raddr = ring_rdata;
        if (cnt_q == '0) begin
          succ_d = ring_rdata;
        end
        if ((ring_rdata == a_q) || last_step) begin
          res_d.status     = fofrm_pkg::ST_QUERY;
          res_d.successor  = (cnt_q == '0) ? ring_rdata : succ_q;
          res_d.group_size = fofrm_pkg::SIZE_W'(cnt_q) + fofrm_pkg::SIZE_W'(1);
          state_d          = fofrm_pkg::S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      fofrm_pkg::S_DONE: begin
        if (out_load) begin
          state_d = fofrm_pkg::S_IDLE;
        end
      end
      default: state_d = fofrm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fofrm_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q    <= in_data_i.first_index;
      b_q    <= in_data_i.second_index;
    end
    cnt_q  <= cnt_d;
    ta_q   <= ta_d;
    succ_q <= succ_d;
    pa_q   <= pa_d;
    res_q  <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> tb/friends_of_friends_ring_merge_unit_checker.sv
`default_nettype none

module friends_of_friends_ring_merge_unit_checker
  import fofrm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_stall_o,
  input  wire in_item_t             in_data_i,
  input  wire logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  input  wire out_item_t            out_data_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [CFG_W-1:0]     pwdata,
  input  wire logic                 pready,
  output int                        fail_count_o,
  output int                        pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [PADDR_W-1:0] LINK_ADDR = PADDR_W'(8 * REG_LINK_DIST_SQ);

  logic signed [POS_BITS-1:0] pos_x [MAX_PARTICLES];
  logic signed [POS_BITS-1:0] pos_y [MAX_PARTICLES];
  logic signed [POS_BITS-1:0] pos_z [MAX_PARTICLES];
  logic [IDX_W-1:0]           ring_succ [MAX_PARTICLES];
  logic [LINK_W-1:0]          link_len_sq;
  out_item_t                  awaited [$];
  out_item_t                  oldest;
  out_item_t                  fresh;

  function automatic longint unsigned axis_sq(logic signed [POS_BITS-1:0] a,
                                              logic signed [POS_BITS-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) begin
      d = -d;
    end
    return longint'(unsigned'(d)) * longint'(unsigned'(d));
  endfunction

  // updates the particle and ring state, returns 1 when the item gives a result
  function automatic bit predict_result(input in_item_t it, output out_item_t res);
    logic [IDX_W-1:0]  a;
    logic [IDX_W-1:0]  b;
    logic [IDX_W-1:0]  j;
    logic [IDX_W-1:0]  hold;
    longint unsigned   dist_sum;
    bit                found;
    int unsigned       steps;
    a = it.first_index;
    b = it.second_index;
    res = '0;
    case (it.mode)
      MODE_LOAD: begin
        pos_x[a] = it.pos_x_in;
        pos_y[a] = it.pos_y_in;
        pos_z[a] = it.pos_z_in;
        ring_succ[a] = a;
        res.status = ST_LOADED;
      end
      MODE_LINK: begin
        dist_sum = axis_sq(pos_x[a], pos_x[b]) + axis_sq(pos_y[a], pos_y[b])
                 + axis_sq(pos_z[a], pos_z[b]);
        if (dist_sum > link_len_sq) begin
          res.status = ST_FAR;
        end else if (a == b) begin
          res.status = ST_SAME;
        end else begin
          found = 1'b0;
          j = a;
          for (steps = 0; steps < MAX_PARTICLES; steps++) begin
            j = ring_succ[j];
            if (j == a) break;
            if (j == b) begin
              found = 1'b1;
              break;
            end
          end
          if (found) begin
            res.status = ST_SAME;
          end else begin
            hold = ring_succ[a];
            ring_succ[a] = ring_succ[b];
            ring_succ[b] = hold;
            res.status = ST_MERGED;
          end
        end
      end
      MODE_QUERY: begin
        res.successor = ring_succ[a];
        j = a;
        steps = 0;
        do begin
          steps++;
          j = ring_succ[j];
        end while (j != a && steps < MAX_PARTICLES);
        res.group_size = SIZE_W'(steps);
        res.status = ST_QUERY;
      end
      default: begin
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_len_sq = '0;
      awaited.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == LINK_ADDR) begin
        link_len_sq = pwdata[LINK_W-1:0];
      end
      if (out_valid_o && !out_stall_i) begin
        if (awaited.size() == 0) begin
          $error("unexpected result: status %0d successor %0d group_size %0d",
                 out_data_o.status, out_data_o.successor, out_data_o.group_size);
          fail_count_o++;
        end else begin
          oldest = awaited.pop_front();
          if (out_data_o.status !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, out_data_o.status);
            fail_count_o++;
          end
          if (out_data_o.successor !== oldest.successor) begin
            $error("successor: expected %0d, got %0d",
                   oldest.successor, out_data_o.successor);
            fail_count_o++;
          end
          if (out_data_o.group_size !== oldest.group_size) begin
            $error("group_size: expected %0d, got %0d",
                   oldest.group_size, out_data_o.group_size);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        if (predict_result(in_data_i, fresh)) begin
          awaited.push_back(fresh);
        end
      end
      pending_o = awaited.size();
    end
  end

endmodule

`default_nettype wire

>>> tb/friends_of_friends_ring_merge_unit_tb.sv
`default_nettype none

module friends_of_friends_ring_merge_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import fofrm_pkg::*;

  localparam logic [1:0]         MODE_UNUSED  = 2'd3;
  localparam logic [PADDR_W-1:0] LINK_ADDR    = PADDR_W'(8 * REG_LINK_DIST_SQ);
  localparam logic [CFG_W-1:0]   LINK_MAX     = (64'd1 << LINK_W) - 64'd1;
  localparam int                 TARGET_ITEMS = 1620;
  localparam int                 MAX_MEMBERS  = 24;
  localparam int                 TAIL_CYCLES  = 32;
  localparam int                 CYCLE_LIMIT  = 2000000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  in_item_t           in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  out_item_t          out_data_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [CFG_W-1:0]   pwdata;
  logic [CFG_W-1:0]   prdata;
  logic               pready;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int sent_count = 0;
  bit calm;

  friends_of_friends_ring_merge_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  friends_of_friends_ring_merge_unit_checker ring_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** friends_of_friends_ring_merge_unit: FAILED **");
      $finish;
    end
  end

  function automatic int idle_cycles();
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic in_item_t scramble();
    in_item_t it;
    it.mode         = 2'($urandom());
    it.first_index  = 12'($urandom());
    it.second_index = 12'($urandom());
    it.pos_x_in     = 24'($urandom());
    it.pos_y_in     = 24'($urandom());
    it.pos_z_in     = 24'($urandom());
    return it;
  endfunction

  function automatic in_item_t load_item(logic [11:0] idx, logic signed [23:0] x,
                                         logic signed [23:0] y, logic signed [23:0] z);
    in_item_t it;
    it = scramble();
    it.mode = MODE_LOAD;
    it.first_index = idx;
    it.pos_x_in = x;
    it.pos_y_in = y;
    it.pos_z_in = z;
    return it;
  endfunction

  function automatic in_item_t link_item(logic [11:0] a, logic [11:0] b);
    in_item_t it;
    it = scramble();
    it.mode = MODE_LINK;
    it.first_index = a;
    it.second_index = b;
    return it;
  endfunction

  function automatic in_item_t query_item(logic [11:0] a);
    in_item_t it;
    it = scramble();
    it.mode = MODE_QUERY;
    it.first_index = a;
    return it;
  endfunction

  function automatic in_item_t noise_item();
    in_item_t it;
    it = scramble();
    it.mode = MODE_UNUSED;
    return it;
  endfunction

  function automatic logic signed [23:0] near(logic signed [23:0] c, int unsigned spread);
    return c + 24'($urandom_range(0, 2 * spread) - spread);
  endfunction

  task automatic send(input in_item_t it);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (it.mode != MODE_UNUSED) sent_count++;
  endtask

  // hold off until every awaited result is back and the block has gone quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_link(input logic [CFG_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LINK_ADDR;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // one cluster of particles: load them all, then link, query and noise among them
  task automatic run_epoch(input int unsigned spread);
    int unsigned        n;
    int unsigned        ops;
    int unsigned        base;
    int unsigned        stride;
    int unsigned        pick;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [23:0] cz;
    logic [11:0]        member [MAX_MEMBERS];
    n = $urandom_range(2, MAX_MEMBERS);
    base = $urandom_range(0, 4095);
    stride = 2 * $urandom_range(0, 2047) + 1;
    cx = 24'($urandom());
    cy = 24'($urandom());
    cz = 24'($urandom());
    for (int k = 0; k < n; k++) begin
      member[k] = 12'(base + k * stride);
      send(load_item(member[k], near(cx, spread), near(cy, spread), near(cz, spread)));
    end
    ops = $urandom_range(n, 3 * n);
    repeat (ops) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        send(link_item(member[$urandom_range(0, n - 1)], member[$urandom_range(0, n - 1)]));
      end else if (pick < 93) begin
        send(query_item(member[$urandom_range(0, n - 1)]));
      end else begin
        send(noise_item());
      end
    end
    // reloading a linked member breaks its ring
    if ($urandom_range(0, 11) == 0) begin
      send(load_item(member[$urandom_range(0, n - 1)], near(cx, spread), near(cy, spread),
                     near(cz, spread)));
      send(query_item(member[$urandom_range(0, n - 1)]));
      send(link_item(member[$urandom_range(0, n - 1)], member[$urandom_range(0, n - 1)]));
    end
  endtask

  initial begin
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      int hold;
      hold = idle_cycles();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    int unsigned      spread;
    logic [CFG_W-1:0] link_len;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_link(64'd25);
    send(load_item(12'd0, 24'd0, 24'd0, 24'd0));
    send(load_item(12'hFFF, 24'd3, 24'd4, 24'd0));
    // distance exactly the link length
    send(link_item(12'd0, 12'hFFF));
    send(query_item(12'd0));
    send(load_item(12'hAAA, 24'h7FFFFF, 24'h800000, 24'h7FFFFF));
    send(load_item(12'h555, 24'h800000, 24'h7FFFFF, 24'h800000));
    send(link_item(12'hAAA, 12'h555));
    send(link_item(12'd0, 12'd0));
    send(load_item(12'd1, 24'd3, 24'd4, 24'd1));
    send(link_item(12'd1, 12'd0));
    send(link_item(12'hFFF, 12'd0));
    settle();
    write_link(LINK_MAX);
    send(link_item(12'hAAA, 12'h555));
    send(link_item(12'd1, 12'd0));
    send(link_item(12'hAAA, 12'd0));
    send(query_item(12'hFFF));
    send(load_item(12'hFFF, 24'h000005, 24'hFFFFFB, 24'h000000));
    send(query_item(12'd0));
    send(link_item(12'd0, 12'h555));
    send('1);
    send(noise_item());
    send(query_item(12'hFFF));

    while (sent_count < TARGET_ITEMS) begin
      spread = 1 << $urandom_range(0, 22);
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 5))
          0:       link_len = '0;
          1:       link_len = LINK_MAX;
          2:       link_len = {$urandom(), $urandom()} & LINK_MAX;
          default: link_len = 64'(spread) * 64'(spread) * 64'($urandom_range(1, 4));
        endcase
        if ($urandom_range(0, 3) == 0) begin
          link_len |= {$urandom(), $urandom()} & ~LINK_MAX;
        end
        settle();
        write_link(link_len);
      end
      run_epoch(spread);
    end

    settle();
    if (fail_count == 0) begin
      $display("** friends_of_friends_ring_merge_unit: PASSED **");
    end else begin
      $display("** friends_of_friends_ring_merge_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> friends_of_friends_ring_merge_unit.f
hdl/fofrm_pkg.sv
hdl/fofrm_ram.sv
hdl/fofrm_dist.sv
hdl/friends_of_friends_ring_merge_unit.sv
tb/friends_of_friends_ring_merge_unit_checker.sv
tb/friends_of_friends_ring_merge_unit_tb.sv
